/* sv/sacl_pkg.sv */
// Shared types and constants for the set-associative LRU cache simulator.
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int IN_ADDR_W    = 48;
	localparam int AGE_W        = 32;
	localparam int CNT_W        = 32;
	localparam int SB_W         = 4;
	localparam int WCNT_W       = 5;
	localparam int OFS_W        = 6;
	localparam int SH_W         = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;
	localparam int OUT_SET_W    = 6;
	localparam int OUT_WAY_W    = 3;
	localparam int OUT_DATA_W   = 112;

	localparam int DEF_ADDR_WIDTH   = 48;
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_NUM_WAYS     = 8;

	localparam logic [2:0] RST_SET_BITS    = 3'd4;
	localparam logic [5:0] RST_OFFSET_BITS = 6'd4;
	localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET_BITS    = 2'd0,
		REG_OFFSET_BITS = 2'd1,
		REG_WAYS_IN_USE = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_STORE  = 2'd1,
		FUNC_MODIFY = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOOK
	} state_t;

endpackage

/* sv/sacl_tag_ram.sv */
// Set-indexed row memory holding valid bits, tags and ages of all ways of a set.
`timescale 1ns / 1ps

module sacl_tag_ram
	import sacl_pkg::*;
#(
	parameter int NUM_SETS  = 64,
	parameter int SET_IDX_W = 6,
	parameter int ROW_W     = 648
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [SET_IDX_W-1:0] rd_set,
	output logic [ROW_W-1:0]     rd_row,
	output logic                 rd_init,
	input  logic                 wr_en,
	input  logic [SET_IDX_W-1:0] wr_set,
	input  logic [ROW_W-1:0]     wr_row
);

	logic [ROW_W-1:0]    mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_init_q;
	logic [ROW_W-1:0]    rd_row_s1;
	logic                rd_init_s1;

	// A row that was never written reads with its init flag clear, so it counts as zero.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_row_s1 <= mem[rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
			rd_init_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_init_q[wr_set] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_s1 <= row_init_q[rd_set];
			end
		end
	end

	assign rd_row  = rd_row_s1;
	assign rd_init = rd_init_s1;

endmodule

/* sv/sacl_lookup.sv */
// Tag compare, victim choice and LRU age update for one set row.
`timescale 1ns / 1ps

module sacl_lookup
	import sacl_pkg::*;
#(
	parameter int ADDR_WIDTH = 48,
	parameter int NUM_WAYS   = 8,
	parameter int WAY_W      = 3,
	parameter int ROW_W      = 648
) (
	input  logic [ROW_W-1:0]      row,
	input  logic                  row_init,
	input  logic [ADDR_WIDTH-1:0] tag,
	input  logic [WCNT_W-1:0]     ways,
	output outcome_t              outcome,
	output logic [WAY_W-1:0]      way,
	output logic [ROW_W-1:0]      new_row
);

	localparam int WB   = 1 + ADDR_WIDTH + AGE_W;
	localparam int P2   = 1 << $clog2(NUM_WAYS);
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	logic [NUM_WAYS-1:0]  act;
	logic [NUM_WAYS-1:0]  vld;
	logic [NUM_WAYS-1:0]  match;
	logic [AGE_W-1:0]     age [NUM_WAYS];
	logic                 nd_act [2*P2];
	logic [AGE_W-1:0]     nd_age [2*P2];
	logic [WAY_W-1:0]     nd_way [2*P2];
	logic                 hit;
	logic                 has_empty;
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_W-1:0]     empty_way;
	logic [WAY_W-1:0]     victim;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			act[w]   = (w < int'(ways));
			vld[w]   = row_init & row[w*WB];
			age[w]   = row_init ? row[w*WB+1+ADDR_WIDTH +: AGE_W] : '0;
			match[w] = act[w] & vld[w] & (row[w*WB+1 +: ADDR_WIDTH] == tag);
		end
	end

	// Lowest matching way, highest empty way.
	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		has_empty = 1'b0;
		hit       = |match;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (act[w] && !vld[w]) begin
				has_empty = 1'b1;
				empty_way = WAY_W'(w);
			end
		end
	end

	// Oldest way by a balanced tree; on equal ages the lower way wins.
	always_comb begin
		for (int n = 0; n < P2; n++) begin
			nd_act[n] = 1'b0;
			nd_age[n] = '0;
			nd_way[n] = '0;
		end
		for (int n = 0; n < P2; n++) begin
			if (n < NUM_WAYS) begin
				nd_act[P2+n] = act[n];
				nd_age[P2+n] = age[n];
			end else begin
				nd_act[P2+n] = 1'b0;
				nd_age[P2+n] = '0;
			end
			nd_way[P2+n] = WAY_W'(n);
		end
		for (int n = P2 - 1; n >= 1; n--) begin
			if (nd_act[2*n+1] && (!nd_act[2*n] || nd_age[2*n+1] > nd_age[2*n])) begin
				nd_act[n] = nd_act[2*n+1];
				nd_age[n] = nd_age[2*n+1];
				nd_way[n] = nd_way[2*n+1];
			end else begin
				nd_act[n] = nd_act[2*n];
				nd_age[n] = nd_age[2*n];
				nd_way[n] = nd_way[2*n];
			end
		end
	end

	assign victim = has_empty ? empty_way : nd_way[1];

	always_comb begin
		outcome = hit ? OUT_HIT : (has_empty ? OUT_FILL : OUT_EVICT);
		way     = hit ? hit_way : victim;
		new_row = row_init ? row : '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (act[w] && vld[w]) begin
				if (match[w]) begin
					new_row[w*WB+1+ADDR_WIDTH +: AGE_W] = '0;
				end else if (age[w] != AGE_MAX) begin
					new_row[w*WB+1+ADDR_WIDTH +: AGE_W] = age[w] + AGE_W'(1);
				end
			end
			if (!hit && victim == WAY_W'(w)) begin
				new_row[w*WB]                        = 1'b1;
				new_row[w*WB+1 +: ADDR_WIDTH]        = tag;
				new_row[w*WB+1+ADDR_WIDTH +: AGE_W]  = '0;
			end
		end
	end

endmodule

/* sv/set_assoc_cache_lru_sim.sv */
// Top level of the set-associative LRU cache hit/miss simulator.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: address; tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: outcome..evictions; tlast
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A load or store passes through accept, set read, and lookup with write-back.
// A modify makes two passes; its store pass reads the row its load pass wrote.
// The row memory has separate read and write ports and a registered read.
// Reset clears the counters and per-set init flags; config takes its defaults.
// A stalled output holds the lookup stage; a new access is taken while the
// last result of the previous one still waits in the output register.

module set_assoc_cache_lru_sim
	import sacl_pkg::*;
#(
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int NUM_WAYS     = DEF_NUM_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_ADDR_W-1:0]  s_axis_tdata,   // [47:0] address
	input  logic [1:0]            s_axis_tuser,   // [1:0] func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] outcome, [7:2] set_num, [10:8] way_index, [42:11] hits_total,
	// [74:43] misses_total, [106:75] evictions_total, [111:107] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,   // last_of_run
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ROW_W     = NUM_WAYS * (1 + ADDR_WIDTH + AGE_W);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Configuration registers.
	logic [2:0]            set_bits_q;
	logic [OFS_W-1:0]      offset_bits_q;
	logic [3:0]            ways_in_use_q;

	// Access registers.
	state_t                state_q, state_d;
	func_t                 func_q;
	logic                  pass2_q;
	logic [SET_IDX_W-1:0]  set_q;
	logic [ADDR_WIDTH-1:0] tag_q;

	// Totals and output register.
	logic [CNT_W-1:0]      hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [CNT_W-1:0]      hit_cnt_d, miss_cnt_d, evict_cnt_d;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_last_q;

	// Address split.
	logic [63:0]           addr_wide;
	logic [ADDR_WIDTH-1:0] addr_in;
	logic [ADDR_WIDTH-1:0] addr_sh;
	logic [SB_W-1:0]       sb;
	logic [SH_W-1:0]       sh;
	logic [SET_IDX_W-1:0]  set_mask;
	logic [SET_IDX_W-1:0]  set_in;
	logic [ADDR_WIDTH-1:0] tag_in;
	logic [WCNT_W-1:0]     ways_eff;

	// Control.
	logic                  in_accept;
	logic                  out_free;
	logic                  proceed;
	logic                  rd_en;
	logic                  last_pass;

	// Memory and lookup.
	logic [ROW_W-1:0]      rd_row;
	logic                  rd_init;
	logic [ROW_W-1:0]      new_row;
	outcome_t              outcome;
	logic [WAY_W-1:0]      way;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= RST_SET_BITS;
			offset_bits_q <= RST_OFFSET_BITS;
			ways_in_use_q <= RST_WAYS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SET_BITS:    set_bits_q    <= cfg_data[2:0];
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_WAYS_IN_USE: ways_in_use_q <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	// Set bits beyond the built set count act as the maximum; a way count of zero
	// acts as one and a count beyond the built ways acts as all of them.
	always_comb begin
		addr_wide = 64'(s_axis_tdata);
		addr_in   = addr_wide[ADDR_WIDTH-1:0];
		sb        = (SB_W'(set_bits_q) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
		                                                       : SB_W'(set_bits_q);
		sh        = SH_W'(sb) + SH_W'(offset_bits_q);
		for (int i = 0; i < SET_IDX_W; i++) begin
			set_mask[i] = (i < int'(sb));
		end
		addr_sh   = addr_in >> offset_bits_q;
		set_in    = addr_sh[SET_IDX_W-1:0] & set_mask;
		tag_in    = addr_in >> sh;
		if (ways_in_use_q == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (WCNT_W'(ways_in_use_q) > WCNT_W'(NUM_WAYS)) begin
			ways_eff = WCNT_W'(NUM_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_in_use_q);
		end
	end

	// Sequencer: idle, read the set row, then look up and write back.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && func_t'(s_axis_tuser) != FUNC_NONE) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOOK;
			ST_LOOK: begin
				if (proceed) begin
					state_d = last_pass ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		rd_en         = (state_q == ST_READ);
		out_free      = !m_valid_q || m_axis_tready;
		proceed       = (state_q == ST_LOOK) && out_free;
		in_accept     = s_axis_tvalid && s_axis_tready;
		last_pass     = !(func_q == FUNC_MODIFY && !pass2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				pass2_q <= 1'b0;
			end else if (proceed) begin
				pass2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func_t'(s_axis_tuser);
			set_q  <= set_in;
			tag_q  <= tag_in;
		end
	end

	sacl_tag_ram #(
		.NUM_SETS  (NUM_SETS),
		.SET_IDX_W (SET_IDX_W),
		.ROW_W     (ROW_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_set  (set_q),
		.rd_row  (rd_row),
		.rd_init (rd_init),
		.wr_en   (proceed),
		.wr_set  (set_q),
		.wr_row  (new_row)
	);

	sacl_lookup #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.NUM_WAYS   (NUM_WAYS),
		.WAY_W      (WAY_W),
		.ROW_W      (ROW_W)
	) u_lookup (
		.row      (rd_row),
		.row_init (rd_init),
		.tag      (tag_q),
		.ways     (ways_eff),
		.outcome  (outcome),
		.way      (way),
		.new_row  (new_row)
	);

	// Saturating totals as they stand after this pass.
	always_comb begin
		hit_cnt_d   = hit_cnt_q;
		miss_cnt_d  = miss_cnt_q;
		evict_cnt_d = evict_cnt_q;
		if (outcome == OUT_HIT) begin
			if (hit_cnt_q != CNT_MAX) hit_cnt_d = hit_cnt_q + CNT_W'(1);
		end else begin
			if (miss_cnt_q != CNT_MAX) miss_cnt_d = miss_cnt_q + CNT_W'(1);
			if (outcome == OUT_EVICT && evict_cnt_q != CNT_MAX) begin
				evict_cnt_d = evict_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (proceed) begin
				hit_cnt_q   <= hit_cnt_d;
				miss_cnt_q  <= miss_cnt_d;
				evict_cnt_q <= evict_cnt_d;
				m_valid_q   <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proceed) begin
			m_data_q <= {5'd0, evict_cnt_d, miss_cnt_d, hit_cnt_d,
			             OUT_WAY_W'(way), OUT_SET_W'(set_q), outcome};
			m_last_q <= last_pass;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	// Evictions are a subset of misses, so their total never passes the miss total.
	assert property (@(posedge clk) disable iff (!arst_n) evict_cnt_q <= miss_cnt_q)
		else $error("eviction total exceeds miss total");

	// The load pass of a modify never ends the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && func_q == FUNC_MODIFY && !pass2_q) |=> !m_axis_tlast)
		else $error("load pass of modify marked last");

	// Lookup only follows a row read or a stalled lookup.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_LOOK))
		else $error("lookup entered without a row read");

endmodule
